### rtl/ppuc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppuc_pkg
// Shared widths, register indexes, pixel modes and the geometry word of the
// packed pixel unpacker with crop window.
// ----------------------------------------------------------------------------
package ppuc_pkg;

  localparam int DEFAULT_MAX_DIM = 4096;

  localparam int BYTE_W     = 8;
  localparam int PIX_W      = 16;
  localparam int MODE_W     = 2;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_X_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_X_END   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_Y_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_Y_END   = 3'd6;

  // pixel modes
  localparam logic [MODE_W-1:0] MODE_8BIT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_12BIT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_16BIT  = 2'd2;

  // reset values
  localparam logic [MODE_W-1:0] RST_MODE = MODE_16BIT;
  localparam logic [DIM_W-1:0]  RST_DIM  = 13'd4096;
  localparam logic [POS_W-1:0]  RST_POS  = 12'd0;

  typedef struct packed {
    logic              phase_clr;
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [POS_W-1:0]  x_first;
    logic [DIM_W-1:0]  x_end;
    logic [POS_W-1:0]  y_first;
    logic [DIM_W-1:0]  y_end;
  } geom_t;

  typedef struct packed {
    logic             fire;
    logic [PIX_W-1:0] value;
  } pix_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > cap) r = cap;
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

### rtl/packed_pixel_unpack_crop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_pixel_unpack_crop
// Raw camera byte stream to 16-bit pixels with a crop window.
// ----------------------------------------------------------------------------
// Takes one raw byte per clock on the byte channel and gives 16-bit pixels
// on the pixel channel: 8-bit, packed 12-bit (three bytes, two pixels) or
// little-endian 16-bit. Only pixels inside the crop window come out; row_end
// and frame_end mark the last kept pixel of a row and of the frame. A byte
// passes through an input register and one step of unpack and window logic
// into the result register, and a byte is taken every cycle while the pixel
// side keeps up. Write the configuration only while no bytes are in flight;
// a pixel mode write restarts the byte grouping.
// ----------------------------------------------------------------------------
module packed_pixel_unpack_crop #(
  parameter int MAX_DIM = ppuc_pkg::DEFAULT_MAX_DIM
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppuc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppuc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  input  logic [ppuc_pkg::BYTE_W-1:0]     raw_byte,
  output logic                            pixel_valid,
  input  logic                            pixel_ready,
  output logic [ppuc_pkg::PIX_W-1:0]      pixel_value,
  output logic                            row_end,
  output logic                            frame_end
);
  import ppuc_pkg::*;

  geom_t geom;
  pix_t  pix;
  logic  advance;

  ppuc_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  ppuc_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .raw_byte   (raw_byte),
    .geom       (geom),
    .advance    (advance),
    .pix        (pix)
  );

  ppuc_crop #(
    .MAX_DIM (MAX_DIM)
  ) u_crop (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .pix         (pix),
    .advance     (advance),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_value (pixel_value),
    .row_end     (row_end),
    .frame_end   (frame_end)
  );

endmodule

### rtl/ppuc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppuc_cfg
// Configuration registers and the registered clamped crop geometry.
// ----------------------------------------------------------------------------
module ppuc_cfg #(
  parameter int MAX_DIM = ppuc_pkg::DEFAULT_MAX_DIM
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppuc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppuc_pkg::CFG_DATA_W-1:0] cfg_data,
  output ppuc_pkg::geom_t                 geom
);
  import ppuc_pkg::*;

  localparam int DIM_MAX_VAL = (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] DIM_CAP =
    DIM_W'((MAX_DIM > DIM_MAX_VAL) ? DIM_MAX_VAL : MAX_DIM);

  logic [MODE_W-1:0] pixel_mode;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [POS_W-1:0]  crop_x_first;
  logic [DIM_W-1:0]  crop_x_end;
  logic [POS_W-1:0]  crop_y_first;
  logic [DIM_W-1:0]  crop_y_end;

  logic [DIM_W-1:0]  width;
  logic [DIM_W-1:0]  height;
  logic [DIM_W-1:0]  x_end;
  logic [DIM_W-1:0]  y_end;
  logic              wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode   <= RST_MODE;
      image_width  <= RST_DIM;
      image_height <= RST_DIM;
      crop_x_first <= RST_POS;
      crop_x_end   <= RST_DIM;
      crop_y_first <= RST_POS;
      crop_y_end   <= RST_DIM;
    end else if (wr) begin
      case (cfg_index)
        REG_PIXEL_MODE:   pixel_mode   <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_CROP_X_FIRST: crop_x_first <= cfg_data[POS_W-1:0];
        REG_CROP_X_END:   crop_x_end   <= cfg_data[DIM_W-1:0];
        REG_CROP_Y_FIRST: crop_y_first <= cfg_data[POS_W-1:0];
        REG_CROP_Y_END:   crop_y_end   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp image size and window ends
  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= clamp_dim(RST_DIM, DIM_CAP);
      height <= clamp_dim(RST_DIM, DIM_CAP);
      x_end  <= min_dim(RST_DIM, clamp_dim(RST_DIM, DIM_CAP));
      y_end  <= min_dim(RST_DIM, clamp_dim(RST_DIM, DIM_CAP));
    end else begin
      width  <= clamp_dim(image_width, DIM_CAP);
      height <= clamp_dim(image_height, DIM_CAP);
      x_end  <= min_dim(crop_x_end, clamp_dim(image_width, DIM_CAP));
      y_end  <= min_dim(crop_y_end, clamp_dim(image_height, DIM_CAP));
    end
  end

  always_comb begin
    geom.phase_clr = wr && (cfg_index == REG_PIXEL_MODE);
    geom.mode      = pixel_mode;
    geom.width     = width;
    geom.height    = height;
    geom.x_first   = crop_x_first;
    geom.x_end     = x_end;
    geom.y_first   = crop_y_first;
    geom.y_end     = y_end;
  end

endmodule

### rtl/ppuc_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppuc_unpack
// Input byte register and byte-to-pixel assembly for the three pixel modes.
// ----------------------------------------------------------------------------
module ppuc_unpack (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_ready,
  input  logic [ppuc_pkg::BYTE_W-1:0] raw_byte,
  input  ppuc_pkg::geom_t             geom,
  input  logic                        advance,
  output ppuc_pkg::pix_t              pix
);
  import ppuc_pkg::*;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  logic              byte_vld;
  logic [BYTE_W-1:0] byte_reg;
  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [BYTE_W-1:0] held;
  logic [BYTE_W-1:0] held_next;
  logic [PIX_W-1:0]  value;
  logic              have;
  logic              step;

  assign byte_ready = !byte_vld || advance;
  assign step       = byte_vld && advance;

  always_comb begin
    value      = '0;
    have       = 1'b0;
    phase_next = phase;
    held_next  = held;
    case (geom.mode)
      MODE_8BIT: begin
        value = {8'h00, byte_reg};
        have  = 1'b1;
      end
      MODE_12BIT: begin
        case (phase)
          PH_0: begin
            held_next  = byte_reg;
            phase_next = PH_1;
          end
          PH_1: begin
            value      = {4'h0, held, byte_reg[7:4]};
            have       = 1'b1;
            held_next  = byte_reg;
            phase_next = PH_2;
          end
          default: begin
            value      = {4'h0, held[3:0], byte_reg};
            have       = 1'b1;
            phase_next = PH_0;
          end
        endcase
      end
      MODE_16BIT: begin
        case (phase)
          PH_0: begin
            held_next  = byte_reg;
            phase_next = PH_1;
          end
          default: begin
            value      = {byte_reg, held};
            have       = 1'b1;
            phase_next = PH_0;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
      phase    <= PH_0;
      held     <= '0;
    end else begin
      if (byte_ready) byte_vld <= byte_valid;
      if (geom.phase_clr) phase <= PH_0;
      else if (step) phase <= phase_next;
      if (step) held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) byte_reg <= raw_byte;
  end

  assign pix.fire  = byte_vld && have;
  assign pix.value = value;

endmodule

### rtl/ppuc_crop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppuc_crop
// Column and row counters, crop window test and the result word register.
// ----------------------------------------------------------------------------
module ppuc_crop #(
  parameter int MAX_DIM = ppuc_pkg::DEFAULT_MAX_DIM
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ppuc_pkg::geom_t            geom,
  input  ppuc_pkg::pix_t             pix,
  output logic                       advance,
  output logic                       pixel_valid,
  input  logic                       pixel_ready,
  output logic [ppuc_pkg::PIX_W-1:0] pixel_value,
  output logic                       row_end,
  output logic                       frame_end
);
  import ppuc_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);
  localparam int CMP_W = ((CW > DIM_W) ? CW : DIM_W) + 1;

  logic [CW-1:0]    column_count;
  logic [CW-1:0]    row_count;
  logic [CW-1:0]    column_count_next;
  logic [CW-1:0]    row_count_next;
  logic [CMP_W-1:0] col;
  logic [CMP_W-1:0] row;
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] row_inc;
  logic [CMP_W-1:0] width;
  logic [CMP_W-1:0] height;
  logic [CMP_W-1:0] x_first;
  logic [CMP_W-1:0] x_end;
  logic [CMP_W-1:0] y_first;
  logic [CMP_W-1:0] y_end;
  logic             in_win;
  logic             re;
  logic             fe;
  logic             take;

  assign advance = !pixel_valid || pixel_ready;
  assign take    = pix.fire && advance;

  always_comb begin
    col     = CMP_W'(column_count);
    row     = CMP_W'(row_count);
    col_inc = col + CMP_W'(1);
    row_inc = row + CMP_W'(1);
    width   = CMP_W'(geom.width);
    height  = CMP_W'(geom.height);
    x_first = CMP_W'(geom.x_first);
    x_end   = CMP_W'(geom.x_end);
    y_first = CMP_W'(geom.y_first);
    y_end   = CMP_W'(geom.y_end);
    in_win  = (col >= x_first) && (col < x_end) && (row >= y_first) && (row < y_end);
    re      = (col_inc == x_end);
    fe      = re && (row_inc == y_end);
    column_count_next = col_inc[CW-1:0];
    row_count_next    = row_count;
    if (col_inc >= width) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= height) ? '0 : row_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pixel_valid  <= 1'b0;
    end else begin
      if (take) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (advance) pixel_valid <= take && in_win;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixel_value <= pix.value;
      row_end     <= re;
      frame_end   <= fe;
    end
  end

endmodule
